// ===== hw/rtl/gptot_pkg.sv =====
package gptot_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // action codes
    localparam logic [1:0] ACT_FIX  = 2'd0;
    localparam logic [1:0] ACT_PPS  = 2'd1;
    localparam logic [1:0] ACT_CONV = 2'd2;

    // quality codes
    localparam logic [1:0] QUAL_UNLOCKED = 2'd0;
    localparam logic [1:0] QUAL_FIXES    = 2'd1;
    localparam logic [1:0] QUAL_PPS      = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PPS_STALE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PPS_DISAGREE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_FIXES   = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [62:0]        mono_us;
        logic signed [63:0] gps_time_us;
        logic [31:0]        serial_delay_us;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] converted_gps_us;
        logic signed [63:0] offset_in_use_us;
        logic [1:0]         quality;
        logic               locked;
        logic               pps_rejected;
    } t_out_word;

    typedef struct packed {
        logic [31:0] swap_age_us;
        logic [31:0] pps_stale_us;
        logic [31:0] pps_disagree_us;
        logic [15:0] lock_fixes;
    } t_cfg;

    // accepted word plus the offset samples formed on the way in
    typedef struct packed {
        t_in_word           word;
        logic signed [63:0] fix_sample;
        logic signed [63:0] pps_sample;
    } t_stage;

endpackage

// ===== hw/rtl/gps_pps_timebase_offset_tracker.sv =====
// gps/pps timebase offset tracker
//
// input channel (i_in_valid / o_in_ready / i_in_word): one word per event,
// a navigation fix, a pps edge or a plain conversion request.
// output channel (o_out_valid / i_out_ready / o_out_word): exactly one word
// per input word, in order: converted gps time, offset in use, quality,
// lock flag and pps reject flag.
// config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
// always ready, write only while no word is in flight.
//
// an accepted word is held in the input register, then passes through the
// tracker update into the result register, from which it leaves.
// throughput: one word per cycle while results are taken, set by the single
// update pass through the tracker state between input and result registers.
// a stalled receiver holds the result register; the input register keeps
// its word and o_in_ready drops until the result is taken.
// reset (synchronous, active low) empties both registers, clears buckets,
// fix count and pps state, and loads the default register values.
module gps_pps_timebase_offset_tracker
    import gptot_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      w_cfg;
    t_stage    w_stage;
    t_out_word w_result;
    logic      w_stage_valid;
    logic      w_advance;
    logic      w_fire;

    assign w_fire = w_stage_valid && w_advance;

    gptot_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    gptot_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_word     (i_in_word),
        .o_in_ready    (o_in_ready),
        .i_advance     (w_advance),
        .o_stage_valid (w_stage_valid),
        .o_stage       (w_stage)
    );

    gptot_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_stage  (w_stage),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    gptot_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_fire),
        .i_result    (w_result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_advance   (w_advance)
    );

endmodule

// ===== hw/rtl/gptot_cfg.sv =====
module gptot_cfg
    import gptot_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HALF_WINDOW:  n_cfg.swap_age_us     = i_cfg_data;
                CFG_PPS_STALE:    n_cfg.pps_stale_us    = i_cfg_data;
                CFG_PPS_DISAGREE: n_cfg.pps_disagree_us = i_cfg_data;
                CFG_LOCK_FIXES:   n_cfg.lock_fixes      = i_cfg_data[15:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.swap_age_us     <= 32'd30000000;
            r_cfg.pps_stale_us    <= 32'd2000000;
            r_cfg.pps_disagree_us <= 32'd1000;
            r_cfg.lock_fixes      <= 16'd5;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== hw/rtl/gptot_in_stage.sv =====
module gptot_in_stage
    import gptot_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_word i_in_word,
    output logic     o_in_ready,
    input  logic     i_advance,
    output logic     o_stage_valid,
    output t_stage   o_stage
);

    logic   r_vld;
    t_stage r_stage;
    t_stage n_stage;
    logic   w_take;

    assign o_in_ready    = !r_vld || i_advance;
    assign w_take        = i_in_valid && o_in_ready;
    assign o_stage_valid = r_vld;
    assign o_stage       = r_stage;

    // offset samples: fix = arrival - serial delay - gps, pps = edge - gps
    always_comb begin
        n_stage.word       = i_in_word;
        n_stage.fix_sample = $signed({1'b0, i_in_word.mono_us})
                             - $signed({32'd0, i_in_word.serial_delay_us})
                             - i_in_word.gps_time_us;
        n_stage.pps_sample = $signed({1'b0, i_in_word.mono_us}) - i_in_word.gps_time_us;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_stage <= n_stage;
        end
    end

endmodule

// ===== hw/rtl/gptot_core.sv =====
module gptot_core
    import gptot_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_stage    i_stage,
    input  t_cfg      i_cfg,
    output t_out_word o_result
);

    localparam int CMP_W = 33;

    logic                   r_valid [2];
    logic                   r_cur;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_pps_ok;
    logic signed [63:0]     r_filt;
    logic signed [63:0]     r_min [2];
    logic [62:0]            r_start [2];
    logic signed [63:0]     r_pps_off;
    logic [62:0]            r_edge;

    logic                   n_valid [2];
    logic                   n_cur;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   n_pps_ok;
    logic signed [63:0]     n_filt;
    logic signed [63:0]     n_min [2];
    logic [62:0]            n_start [2];
    logic signed [63:0]     n_pps_off;
    logic [62:0]            n_edge;

    logic [62:0]            w_mono;
    logic signed [63:0]     w_age;
    logic signed [63:0]     w_edge_age;
    logic signed [63:0]     w_ref;
    logic signed [64:0]     w_diff;
    logic [64:0]            w_mag;
    logic                   w_lock_old;
    logic                   w_lock_new;
    logic                   w_rej;
    logic signed [63:0]     w_use;

    assign w_mono     = i_stage.word.mono_us;
    assign w_age      = $signed({1'b0, w_mono}) - $signed({1'b0, r_start[r_cur]});
    assign w_edge_age = $signed({1'b0, w_mono}) - $signed({1'b0, r_edge});
    assign w_lock_old = {{(CMP_W-COUNT_WIDTH){1'b0}}, r_count} >=
                        {{(CMP_W-16){1'b0}}, i_cfg.lock_fixes};
    assign w_lock_new = {{(CMP_W-COUNT_WIDTH){1'b0}}, n_count} >=
                        {{(CMP_W-16){1'b0}}, i_cfg.lock_fixes};

    // exact disagreement magnitude, one bit wider than the offsets
    assign w_ref  = r_pps_ok ? r_pps_off : r_filt;
    assign w_diff = {i_stage.pps_sample[63], i_stage.pps_sample} - {w_ref[63], w_ref};
    assign w_mag  = w_diff[64] ? 65'(-w_diff) : 65'(w_diff);

    always_comb begin
        n_valid   = r_valid;
        n_cur     = r_cur;
        n_count   = r_count;
        n_pps_ok  = r_pps_ok;
        n_filt    = r_filt;
        n_min     = r_min;
        n_start   = r_start;
        n_pps_off = r_pps_off;
        n_edge    = r_edge;
        w_rej     = 1'b0;

        case (i_stage.word.action)
            ACT_FIX: begin
                if (!r_valid[r_cur]) begin
                    n_min[r_cur]   = i_stage.fix_sample;
                    n_start[r_cur] = w_mono;
                    n_valid[r_cur] = 1'b1;
                end else if (w_age >= $signed({32'd0, i_cfg.swap_age_us})) begin
                    // current bucket aged out: restart the other one
                    n_cur          = !r_cur;
                    n_min[!r_cur]   = i_stage.fix_sample;
                    n_start[!r_cur] = w_mono;
                    n_valid[!r_cur] = 1'b1;
                end else if (i_stage.fix_sample < r_min[r_cur]) begin
                    n_min[r_cur] = i_stage.fix_sample;
                end
                if (r_count != {COUNT_WIDTH{1'b1}}) begin
                    n_count = r_count + 1'b1;
                end
                if (n_valid[0] && n_valid[1]) begin
                    n_filt = (n_min[1] < n_min[0]) ? n_min[1] : n_min[0];
                end else if (n_valid[0]) begin
                    n_filt = n_min[0];
                end else if (n_valid[1]) begin
                    n_filt = n_min[1];
                end
                if (r_pps_ok && ($signed({32'd0, i_cfg.pps_stale_us}) < w_edge_age)) begin
                    n_pps_ok = 1'b0;
                end
            end
            ACT_PPS: begin
                // negative top-of-second edges are ignored
                if (!i_stage.word.gps_time_us[63]) begin
                    if ((r_pps_ok || w_lock_old) &&
                        (w_mag > {33'd0, i_cfg.pps_disagree_us})) begin
                        n_pps_ok = 1'b0;
                        w_rej    = 1'b1;
                    end else begin
                        n_pps_off = i_stage.pps_sample;
                        n_pps_ok  = 1'b1;
                        n_edge    = w_mono;
                    end
                end
            end
            default: begin
                n_pps_ok = r_pps_ok;
            end
        endcase
    end

    assign w_use = n_pps_ok ? n_pps_off : n_filt;

    always_comb begin
        o_result.converted_gps_us = $signed({1'b0, w_mono}) - w_use;
        o_result.offset_in_use_us = w_use;
        o_result.quality          = n_pps_ok ? QUAL_PPS :
                                    (w_lock_new ? QUAL_FIXES : QUAL_UNLOCKED);
        o_result.locked           = w_lock_new;
        o_result.pps_rejected     = w_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
            r_valid[1] <= 1'b0;
            r_cur      <= 1'b0;
            r_count    <= '0;
            r_pps_ok   <= 1'b0;
            r_filt     <= '0;
        end else if (i_fire) begin
            r_valid  <= n_valid;
            r_cur    <= n_cur;
            r_count  <= n_count;
            r_pps_ok <= n_pps_ok;
            r_filt   <= n_filt;
        end
    end

    // read only while the matching valid flag is set
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_min     <= n_min;
            r_start   <= n_start;
            r_pps_off <= n_pps_off;
            r_edge    <= n_edge;
        end
    end

endmodule

// ===== hw/rtl/gptot_out_stage.sv =====
module gptot_out_stage
    import gptot_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_word i_result,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    output logic      o_advance
);

    logic      r_vld;
    t_out_word r_word;

    // result register is free when empty or being taken this cycle
    assign o_advance   = !r_vld || i_out_ready;
    assign o_out_valid = r_vld;
    assign o_out_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_advance) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_result;
        end
    end

endmodule

// ===== hw/rtl/gptot_checker.sv =====
module gptot_checker
    import gptot_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // a stalled result keeps its word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    // nothing comes out right after reset
    assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    // fix-locked quality needs the lock flag
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.quality == QUAL_FIXES) |-> o_out_word.locked)
        else $error("quality locked without lock flag");

    // a rejected edge leaves pps invalid
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.pps_rejected |-> (o_out_word.quality != QUAL_PPS))
        else $error("pps valid after rejected edge");

    // unlocked quality only when not locked
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.locked |-> (o_out_word.quality != QUAL_UNLOCKED))
        else $error("locked but quality unlocked");

endmodule

bind gps_pps_timebase_offset_tracker gptot_checker u_gptot_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// ===== tb/gptot_result_checker.sv =====
module gptot_result_checker
    import gptot_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_word              i_in_word,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_word             i_out_word,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [31:0] HALF_WINDOW_RST  = 32'd30_000_000;
    localparam logic [31:0] PPS_STALE_RST    = 32'd2_000_000;
    localparam logic [31:0] PPS_DISAGREE_RST = 32'd1000;
    localparam logic [15:0] LOCK_FIXES_RST   = 16'd5;

    t_cfg                   regs;
    logic [63:0]            bkt_min [2];
    logic [63:0]            bkt_start [2];
    logic                   bkt_vld [2];
    logic                   cur_bkt;
    logic [63:0]            filt_off;
    logic [COUNT_WIDTH-1:0] fix_cnt;
    logic                   pps_vld;
    logic [63:0]            pps_off;
    logic [63:0]            pps_edge_mono;
    t_out_word              expected_q [$];
    int                     fails = 0;
    int                     words_seen = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // one tracker update per accepted word, gives the word the block must answer with
    task automatic advance_timebase(input t_in_word w, output t_out_word r);
        logic [63:0] mono;
        logic [63:0] smp;
        logic [63:0] age;
        logic [63:0] ref_off;
        logic [63:0] mag;
        logic [63:0] low;
        logic [63:0] use_off;
        logic        c;
        logic        any;
        logic        rej;
        logic        lck;
        mono = {1'b0, w.mono_us};
        rej  = 1'b0;
        case (w.action)
            ACT_FIX: begin
                smp = mono - {32'd0, w.serial_delay_us} - w.gps_time_us;
                c   = cur_bkt;
                age = mono - bkt_start[c];
                if (!bkt_vld[c]) begin
                    bkt_min[c]   = smp;
                    bkt_start[c] = mono;
                    bkt_vld[c]   = 1'b1;
                end else if ($signed(age) >= $signed({32'd0, regs.swap_age_us})) begin
                    c            = ~c;
                    cur_bkt      = c;
                    bkt_min[c]   = smp;
                    bkt_start[c] = mono;
                    bkt_vld[c]   = 1'b1;
                end else if ($signed(smp) < $signed(bkt_min[c])) begin
                    bkt_min[c] = smp;
                end
                if (fix_cnt != {COUNT_WIDTH{1'b1}})
                    fix_cnt = fix_cnt + 1'b1;
                any = 1'b0;
                low = '0;
                for (int i = 0; i < 2; i++) begin
                    if (bkt_vld[i] && (!any || $signed(bkt_min[i]) < $signed(low))) begin
                        low = bkt_min[i];
                        any = 1'b1;
                    end
                end
                if (any)
                    filt_off = low;
                age = mono - pps_edge_mono;
                if (pps_vld && $signed(age) > $signed({32'd0, regs.pps_stale_us}))
                    pps_vld = 1'b0;
            end
            ACT_PPS: begin
                // negative top-of-second: edge has no effect
                if (!w.gps_time_us[63]) begin
                    smp     = mono - w.gps_time_us;
                    ref_off = pps_vld ? pps_off : filt_off;
                    if (pps_vld || fix_cnt >= regs.lock_fixes) begin
                        // magnitude kept exact as an unsigned 64-bit difference
                        mag = ($signed(smp) < $signed(ref_off)) ? ref_off - smp : smp - ref_off;
                        if (mag > {32'd0, regs.pps_disagree_us}) begin
                            pps_vld = 1'b0;
                            rej     = 1'b1;
                        end
                    end
                    if (!rej) begin
                        pps_off       = smp;
                        pps_vld       = 1'b1;
                        pps_edge_mono = mono;
                    end
                end
            end
            default: ;
        endcase
        lck                = fix_cnt >= regs.lock_fixes;
        use_off            = pps_vld ? pps_off : filt_off;
        r.converted_gps_us = mono - use_off;
        r.offset_in_use_us = use_off;
        r.quality          = pps_vld ? QUAL_PPS : (lck ? QUAL_FIXES : QUAL_UNLOCKED);
        r.locked           = lck;
        r.pps_rejected     = rej;
    endtask

    task automatic note_field(input string what, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            fails++;
            if (fails <= 10)
                $display("%s mismatch on output word %0d: expected %h, got %h",
                         what, words_seen, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        t_out_word got_w;
        if (!i_rst_n) begin
            regs.swap_age_us     = HALF_WINDOW_RST;
            regs.pps_stale_us    = PPS_STALE_RST;
            regs.pps_disagree_us = PPS_DISAGREE_RST;
            regs.lock_fixes      = LOCK_FIXES_RST;
            for (int i = 0; i < 2; i++) begin
                bkt_min[i]   = '0;
                bkt_start[i] = '0;
                bkt_vld[i]   = 1'b0;
            end
            cur_bkt       = 1'b0;
            filt_off      = '0;
            fix_cnt       = '0;
            pps_vld       = 1'b0;
            pps_off       = '0;
            pps_edge_mono = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HALF_WINDOW:  regs.swap_age_us     = i_cfg_data;
                    CFG_PPS_STALE:    regs.pps_stale_us    = i_cfg_data;
                    CFG_PPS_DISAGREE: regs.pps_disagree_us = i_cfg_data;
                    CFG_LOCK_FIXES:   regs.lock_fixes      = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                advance_timebase(i_in_word, exp_w);
                expected_q.push_back(exp_w);
            end
            if (i_out_valid && i_out_ready) begin
                got_w = i_out_word;
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("output word %0d with nothing expected: %h", words_seen, got_w);
                end else begin
                    exp_w = expected_q.pop_front();
                    note_field("converted_gps_us", exp_w.converted_gps_us,
                               got_w.converted_gps_us);
                    note_field("offset_in_use_us", exp_w.offset_in_use_us,
                               got_w.offset_in_use_us);
                    note_field("quality", exp_w.quality, got_w.quality);
                    note_field("locked", exp_w.locked, got_w.locked);
                    note_field("pps_rejected", exp_w.pps_rejected, got_w.pps_rejected);
                end
                words_seen++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
    end

endmodule

// ===== tb/tb_gps_pps_timebase_offset_tracker.sv =====
module tb_gps_pps_timebase_offset_tracker;
    import gptot_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam logic [1:0]  ACT_SPARE   = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_word              in_word = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_word             out_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    n_fail;
    int                    n_pending;
    int unsigned           cycle_cnt = 0;
    bit                    calm = 1'b0;

    // traffic model: local clock now and the true mono-to-gps offset
    logic [62:0]           now_us;
    logic [63:0]           true_off;

    gps_pps_timebase_offset_tracker u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    gptot_result_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (n_fail),
        .o_pending    (n_pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_gps_pps_timebase_offset_tracker NOT OK");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_word make_word(input logic [1:0] act, input logic [62:0] mono,
                                           input logic [63:0] gps, input logic [31:0] ser);
        t_in_word w;
        w.action          = act;
        w.mono_us         = mono;
        w.gps_time_us     = gps;
        w.serial_delay_us = ser;
        return w;
    endfunction

    // valid stays up across back-to-back words, only dropped for a gap
    task automatic push_word(input t_in_word w);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(input logic [31:0] hw, input logic [31:0] st,
                                input logic [31:0] dis, input logic [31:0] lk);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [31:0]          vals [4];
        idx  = '{CFG_HALF_WINDOW, CFG_PPS_STALE, CFG_PPS_DISAGREE, CFG_LOCK_FIXES};
        vals = '{hw, st, dis, lk};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic next_event(input bit fixes_only);
        int          r;
        int          kind;
        logic [31:0] ser;
        logic [63:0] err;
        logic [63:0] gps;
        logic [38:0] jump;
        logic [1:0]  act;
        logic [62:0] mono;
        r = $urandom_range(0, 99);
        if (r < 60)
            now_us = now_us + 63'($urandom_range(50_000, 1_100_000));
        else if (r < 75)
            now_us = now_us + 63'($urandom_range(1, 1000));
        else if (r < 88)
            now_us = now_us + 63'($urandom_range(2_000_000, 40_000_000));
        else if (r < 95)
            now_us = now_us + 63'($urandom);
        else if (now_us > 63'd3_000_000)
            now_us = now_us - 63'($urandom_range(0, 3_000_000));  // local clock steps back
        if ($urandom_range(0, 19) == 0)
            true_off = true_off + 64'($urandom_range(0, 2000)) - 64'd1000;
        if ($urandom_range(0, 149) == 0) begin
            jump     = 39'(rand64());
            true_off = {{25{jump[38]}}, jump};
        end
        kind = fixes_only ? 0 : $urandom_range(0, 99);
        ser  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200_000);
        if (kind < 55) begin
            gps = {1'b0, now_us} - 64'(ser) - true_off - 64'($urandom_range(0, 5000));
            push_word(make_word(ACT_FIX, now_us, gps, ser));
        end else if (kind < 80) begin
            r = $urandom_range(0, 9);
            if (r < 7)
                err = 64'($urandom_range(0, 2000)) - 64'd1000;
            else if (r < 9)
                err = 64'($urandom_range(0, 100_000)) - 64'd50_000;
            else
                err = rand64();
            gps = {1'b0, now_us} - true_off + err;
            push_word(make_word(ACT_PPS, now_us, gps, ser));
        end else if (kind < 92) begin
            act  = $urandom_range(0, 1) ? ACT_CONV : ACT_SPARE;
            mono = ($urandom_range(0, 3) == 0) ? 63'(rand64())
                                               : now_us + 63'($urandom_range(0, 5_000_000));
            push_word(make_word(act, mono, rand64(), $urandom));
        end else begin
            push_word(make_word(2'($urandom), 63'(rand64()), rand64(), $urandom));
        end
    endtask

    initial begin
        int run;
        int stall;
        forever begin
            run = $urandom_range(1, 40);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = idle_len();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial begin
        logic [40:0] start;
        logic [38:0] off;
        start    = 41'(rand64());
        off      = 39'(rand64());
        now_us   = {20'd0, 2'b01, start};
        true_off = {{25{off[38]}}, off};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed words under the reset register values
        push_word(make_word(ACT_CONV, 63'd0, 64'd0, 32'd0));
        push_word(make_word(ACT_SPARE, {63{1'b1}}, {64{1'b1}}, 32'hFFFF_FFFF));
        // negative top-of-second is ignored
        push_word(make_word(ACT_PPS, 63'd5_000_000, 64'h8000_0000_0000_0000, $urandom));
        push_word(make_word(ACT_PPS, 63'd5_000_000, 64'd4_000_000, 32'd0));
        push_word(make_word(ACT_PPS, 63'd6_000_500, 64'd5_000_000, 32'd0));
        // pps valid, this edge is 1500 us off
        push_word(make_word(ACT_PPS, 63'd7_002_000, 64'd6_000_000, 32'd0));
        push_word(make_word(ACT_FIX, 63'd10_000_000, 64'd8_899_000, 32'd100_000));
        // local clock backwards: negative bucket age
        push_word(make_word(ACT_FIX, 63'd9_000_000, 64'd8_000_500, 32'd0));
        // bucket age exactly the half window
        push_word(make_word(ACT_FIX, 63'd40_000_000, 64'd38_999_000, 32'd50));
        push_word(make_word(ACT_PPS, 63'd40_500_000, 64'd39_500_000, 32'd0));
        // edge older than the stale limit
        push_word(make_word(ACT_FIX, 63'd42_600_000, 64'd41_600_000, 32'd0));
        // offsets wrapping around 64 bits
        push_word(make_word(ACT_FIX, {63{1'b1}}, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF));
        push_word(make_word(ACT_FIX, 63'd0, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0));
        // disagreement larger than 2^63
        push_word(make_word(ACT_PPS, {63{1'b1}}, 64'd0, 32'd0));
        push_word(make_word(ACT_CONV, 63'd12_345, 64'd0, 32'd0));
        push_word(make_word(ACT_FIX, {63{1'b1}}, 64'd0, 32'd0));
        push_word(make_word(ACT_CONV, {1'b1, 62'd0}, 64'd0, 32'd0));
        settle();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: program_regs(32'd30_000_000, 32'd2_000_000, 32'd1000, 32'd5);
                1: program_regs(32'd1, 32'd0, 32'd0, 32'd0);
                2: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hABCD_FFFF);
                3: program_regs(32'd5_000_000, 32'd1_500_000, 32'd50_000, 32'h5A5A_0003);
                4: program_regs($urandom_range(1, 60_000_000), $urandom_range(0, 5_000_000),
                                $urandom_range(0, 20_000),
                                {16'($urandom), 16'($urandom_range(0, 20))});
                default: program_regs($urandom | 32'd1, $urandom, $urandom, $urandom);
            endcase
            for (int k = 0; k < 180; k++) begin
                if (k % 50 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                next_event(1'b0);
            end
            calm = 1'b0;
            settle();
        end

        // fix-only run with a lock threshold out of reach, then a mixed run
        program_regs(32'd20_000_000, 32'd2_000_000, 32'd1000, 32'h0000_FFFF);
        calm = 1'b1;
        for (int k = 0; k < 60; k++)
            next_event(1'b1);
        calm = 1'b0;
        for (int k = 0; k < 60; k++)
            next_event(1'b0);
        settle();

        if (n_fail == 0 && n_pending == 0)
            $display("tb_gps_pps_timebase_offset_tracker OK");
        else
            $display("tb_gps_pps_timebase_offset_tracker NOT OK");
        $finish;
    end

endmodule

// ===== gps_pps_timebase_offset_tracker.f =====
hw/rtl/gptot_pkg.sv
hw/rtl/gptot_cfg.sv
hw/rtl/gptot_in_stage.sv
hw/rtl/gptot_core.sv
hw/rtl/gptot_out_stage.sv
hw/rtl/gps_pps_timebase_offset_tracker.sv
hw/rtl/gptot_checker.sv
tb/gptot_result_checker.sv
tb/tb_gps_pps_timebase_offset_tracker.sv
